// ===== src/binary_volume_bit_block_packer_top_assert.svh =====
// Assertion macros used by the bit block packer top.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BINARY_VOLUME_BIT_BLOCK_PACKER_TOP_ASSERT_SVH
`define BINARY_VOLUME_BIT_BLOCK_PACKER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BVBP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BVBP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bvbp_pkg.sv =====
// Package for the bit block packer: block geometry, field widths,
// register indexes and the result word type. Depends on nothing.
`default_nettype none

package bvbp_pkg;

    // Block geometry.
    localparam int BLOCK_ROWS_2D    = 8;
    localparam int BLOCK_COLUMNS_2D = 8;
    localparam int BLOCK_EDGE_3D    = 4;

    // Default limits and store size.
    localparam int DEF_MAX_COLUMNS = 512;
    localparam int DEF_MAX_ROWS    = 512;
    localparam int DEF_MAX_DEPTH   = 512;
    localparam int DEF_STORE_DEPTH = 16384;

    // Field widths.
    localparam int PIXEL_W    = 8;
    localparam int DIM_W      = 10;
    localparam int BITS_W     = 64;
    localparam int INDEX_W    = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int LOCAL_W    = 3;
    localparam int BIT_POS_W  = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PORE_COLOR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_DEPTH   = 2'd3;

    // One finished block as it waits in the output queue.
    typedef struct packed {
        logic [BITS_W-1:0]  bits;
        logic [INDEX_W-1:0] index;
        logic               last;
    } bvbp_result_t;

endpackage

`default_nettype wire

// ===== src/bvbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on bvbp_pkg for its default sizes.
`default_nettype none

module bvbp_ram
    import bvbp_pkg::*;
#(
    parameter int WIDTH = BITS_W,
    parameter int DEPTH = DEF_STORE_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; a read of the address being written returns old data.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/binary_volume_bit_block_packer_top.sv =====
// A block's word is ready to be taken once stage one has written it into the output queue.
// One pixel per cycle unless stalled; one read-modify-write of the partial block RAM per pixel.
// A four-word output queue absorbs downstream stalls before the input stalls.
// Reset (aresetn, synchronous, active low) clears the raster counters, the pipeline and
// the queue, and loads the register defaults; the partial block RAM is not cleared.
`default_nettype none
`include "binary_volume_bit_block_packer_top_assert.svh"

module binary_volume_bit_block_packer_top
    import bvbp_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PIXEL_W-1:0]    s_pixel_value,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [BITS_W-1:0]          m_block_bits,
    output logic [INDEX_W-1:0]         m_block_index,
    output logic                       m_last_block
);

    localparam int XW     = $clog2(MAX_COLUMNS + 1);
    localparam int YW     = $clog2(MAX_ROWS + 1);
    localparam int ZW     = $clog2(MAX_DEPTH + 1);
    localparam int SW     = $clog2(STORE_DEPTH);
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Configuration registers.
    logic [PIXEL_W-1:0] pore_color_reg;
    logic [DIM_W-1:0]   image_columns_reg;
    logic [DIM_W-1:0]   image_rows_reg;
    logic [DIM_W-1:0]   image_depth_reg;

    // Raster position, local offsets inside the block and block bases.
    logic [XW-1:0]      x_reg, x_next;
    logic [YW-1:0]      y_reg, y_next;
    logic [ZW-1:0]      z_reg, z_next;
    logic [LOCAL_W-1:0] lx_reg, lx_next, ly_reg, ly_next, lz_reg, lz_next;
    logic [XW-1:0]      bx_reg, bx_next;
    logic [SW-1:0]      row_slot_reg, row_slot_next;
    logic [INDEX_W-1:0] base_idx_reg, base_idx_next;
    logic [INDEX_W-1:0] slab_idx_reg, slab_idx_next;

    // Stage one: the pixel whose block word is being read back.
    logic                 s1_valid_reg;
    logic [SW-1:0]        s1_slot_reg;
    logic [BIT_POS_W-1:0] s1_bit_reg;
    logic                 s1_mark_reg;
    logic                 s1_origin_reg;
    logic                 s1_emit_reg;
    logic [INDEX_W-1:0]   s1_index_reg;
    logic                 s1_last_reg;

    // Forwarding of the word written in the previous cycle.
    logic              fw_valid_reg;
    logic [SW-1:0]     fw_slot_reg;
    logic [BITS_W-1:0] fw_word_reg;

    // Output queue.
    bvbp_result_t   q_mem_reg [QDEPTH];
    logic [QPW-1:0] q_wr_ptr_reg, q_rd_ptr_reg;
    logic [QCW-1:0] q_count_reg;

    // Decoded geometry and per-pixel values.
    logic [XW-1:0]        cols, bcols;
    logic [YW-1:0]        rows, brows;
    logic [ZW-1:0]        depth;
    logic                 flat;
    logic [LOCAL_W-1:0]   bw_m1, bh_m1, bd_m1;
    logic [INDEX_W-1:0]   slab_step;
    logic                 last_x, last_y, last_z;
    logic                 end_x, end_y, end_z;
    logic                 origin;
    logic [BIT_POS_W-1:0] bit_pos;
    logic [SW-1:0]        slot;
    logic [INDEX_W-1:0]   blk_index;
    logic                 accept;
    logic                 restart;
    logic [BITS_W-1:0]    mark_word, prior_word, word;
    logic [BITS_W-1:0]    ram_rdata;
    logic                 push, pop;

    // Clamp the dimensions and derive the block geometry.
    always_comb begin
        if (image_columns_reg == '0) begin
            cols = XW'(1);
        end else if (32'(image_columns_reg) > MAX_COLUMNS) begin
            cols = XW'(MAX_COLUMNS);
        end else begin
            cols = XW'(image_columns_reg);
        end
        if (image_rows_reg == '0) begin
            rows = YW'(1);
        end else if (32'(image_rows_reg) > MAX_ROWS) begin
            rows = YW'(MAX_ROWS);
        end else begin
            rows = YW'(image_rows_reg);
        end
        if (image_depth_reg == '0) begin
            depth = ZW'(1);
        end else if (32'(image_depth_reg) > MAX_DEPTH) begin
            depth = ZW'(MAX_DEPTH);
        end else begin
            depth = ZW'(image_depth_reg);
        end
        flat  = (depth == ZW'(1));
        bw_m1 = flat ? LOCAL_W'(BLOCK_COLUMNS_2D - 1) : LOCAL_W'(BLOCK_EDGE_3D - 1);
        bh_m1 = flat ? LOCAL_W'(BLOCK_ROWS_2D - 1) : LOCAL_W'(BLOCK_EDGE_3D - 1);
        bd_m1 = flat ? '0 : LOCAL_W'(BLOCK_EDGE_3D - 1);
        bcols = flat ? XW'((32'(cols) + BLOCK_COLUMNS_2D - 1) / BLOCK_COLUMNS_2D)
                     : XW'((32'(cols) + BLOCK_EDGE_3D - 1) / BLOCK_EDGE_3D);
        brows = flat ? YW'((32'(rows) + BLOCK_ROWS_2D - 1) / BLOCK_ROWS_2D)
                     : YW'((32'(rows) + BLOCK_EDGE_3D - 1) / BLOCK_EDGE_3D);
        slab_step = INDEX_W'(brows) * INDEX_W'(bcols);
    end

    // Position flags, bit position, slot and block index of the incoming pixel.
    always_comb begin
        last_x  = (x_reg >= cols - XW'(1));
        last_y  = (y_reg >= rows - YW'(1));
        last_z  = (z_reg >= depth - ZW'(1));
        end_x   = (lx_reg == bw_m1) || last_x;
        end_y   = (ly_reg == bh_m1) || last_y;
        end_z   = (lz_reg == bd_m1) || last_z;
        origin  = (lx_reg == '0) && (ly_reg == '0) && (lz_reg == '0);
        if (flat) begin
            bit_pos = BIT_POS_W'(32'(ly_reg) * BLOCK_COLUMNS_2D + 32'(lx_reg));
        end else begin
            bit_pos = BIT_POS_W'((32'(lz_reg) * BLOCK_EDGE_3D + 32'(ly_reg)) * BLOCK_EDGE_3D
                                 + 32'(lx_reg));
        end
        slot      = row_slot_reg + SW'(bx_reg);
        blk_index = base_idx_reg + INDEX_W'(bx_reg);
    end

    assign accept  = s_valid && s_ready;
    assign restart = cfg_wr_en && (cfg_index != REG_PORE_COLOR);

    // Raster walk: step x, then y, then z, carrying block bases along.
    always_comb begin
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        lx_next       = lx_reg;
        ly_next       = ly_reg;
        lz_next       = lz_reg;
        bx_next       = bx_reg;
        row_slot_next = row_slot_reg;
        base_idx_next = base_idx_reg;
        slab_idx_next = slab_idx_reg;
        if (accept) begin
            if (!last_x) begin
                x_next = x_reg + XW'(1);
                if (lx_reg == bw_m1) begin
                    lx_next = '0;
                    bx_next = bx_reg + XW'(1);
                end else begin
                    lx_next = lx_reg + LOCAL_W'(1);
                end
            end else begin
                x_next  = '0;
                lx_next = '0;
                bx_next = '0;
                if (!last_y) begin
                    y_next = y_reg + YW'(1);
                    if (ly_reg == bh_m1) begin
                        ly_next       = '0;
                        base_idx_next = base_idx_reg + INDEX_W'(bcols);
                        if (!flat) begin
                            row_slot_next = row_slot_reg + SW'(bcols);
                        end
                    end else begin
                        ly_next = ly_reg + LOCAL_W'(1);
                    end
                end else begin
                    y_next        = '0;
                    ly_next       = '0;
                    row_slot_next = '0;
                    if (last_z) begin
                        z_next        = '0;
                        lz_next       = '0;
                        slab_idx_next = '0;
                        base_idx_next = '0;
                    end else begin
                        z_next = z_reg + ZW'(1);
                        if (lz_reg == bd_m1) begin
                            lz_next       = '0;
                            slab_idx_next = slab_idx_reg + slab_step;
                            base_idx_next = slab_idx_reg + slab_step;
                        end else begin
                            lz_next       = lz_reg + LOCAL_W'(1);
                            base_idx_next = slab_idx_reg;
                        end
                    end
                end
            end
        end
    end

    // Configuration registers and raster counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pore_color_reg    <= '0;
            image_columns_reg <= DIM_W'(512);
            image_rows_reg    <= DIM_W'(512);
            image_depth_reg   <= DIM_W'(1);
            x_reg             <= '0;
            y_reg             <= '0;
            z_reg             <= '0;
            lx_reg            <= '0;
            ly_reg            <= '0;
            lz_reg            <= '0;
            bx_reg            <= '0;
            row_slot_reg      <= '0;
            base_idx_reg      <= '0;
            slab_idx_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_PORE_COLOR:    pore_color_reg    <= PIXEL_W'(cfg_data);
                    REG_IMAGE_COLUMNS: image_columns_reg <= cfg_data;
                    REG_IMAGE_ROWS:    image_rows_reg    <= cfg_data;
                    REG_IMAGE_DEPTH:   image_depth_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (restart) begin
                x_reg        <= '0;
                y_reg        <= '0;
                z_reg        <= '0;
                lx_reg       <= '0;
                ly_reg       <= '0;
                lz_reg       <= '0;
                bx_reg       <= '0;
                row_slot_reg <= '0;
                base_idx_reg <= '0;
                slab_idx_reg <= '0;
            end else begin
                x_reg        <= x_next;
                y_reg        <= y_next;
                z_reg        <= z_next;
                lx_reg       <= lx_next;
                ly_reg       <= ly_next;
                lz_reg       <= lz_next;
                bx_reg       <= bx_next;
                row_slot_reg <= row_slot_next;
                base_idx_reg <= base_idx_next;
                slab_idx_reg <= slab_idx_next;
            end
        end
    end

    // Stage one control and payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            fw_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_slot_reg   <= slot;
            s1_bit_reg    <= bit_pos;
            s1_mark_reg   <= (s_pixel_value != pore_color_reg);
            s1_origin_reg <= origin;
            s1_emit_reg   <= end_x && end_y && end_z;
            s1_index_reg  <= blk_index;
            s1_last_reg   <= last_x && last_y && last_z;
        end
        fw_slot_reg <= s1_slot_reg;
        fw_word_reg <= word;
    end

    // Partial block store: read on accept, write back the merged word in the next cycle.
    bvbp_ram #(
        .WIDTH (BITS_W),
        .DEPTH (STORE_DEPTH)
    ) u_partial_ram (
        .clk     (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_slot_reg),
        .wr_data (word),
        .rd_en   (accept),
        .rd_addr (slot),
        .rd_data (ram_rdata)
    );

    // Merge the pixel's bit; the block origin starts the word fresh.
    always_comb begin
        mark_word  = s1_mark_reg ? (BITS_W'(1) << s1_bit_reg) : '0;
        prior_word = (fw_valid_reg && (fw_slot_reg == s1_slot_reg)) ? fw_word_reg : ram_rdata;
        word       = s1_origin_reg ? mark_word : (prior_word | mark_word);
    end

    // Output queue; the input stalls while the queue, counting a block pushed this cycle, is full.
    assign push    = s1_valid_reg && s1_emit_reg;
    assign pop     = m_valid && m_ready;
    assign s_ready = (q_count_reg + QCW'(push)) < QCW'(QDEPTH);
    assign m_valid = (q_count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
        end else begin
            if (push) begin
                q_wr_ptr_reg <= q_wr_ptr_reg + QPW'(1);
            end
            if (pop) begin
                q_rd_ptr_reg <= q_rd_ptr_reg + QPW'(1);
            end
            q_count_reg <= q_count_reg + QCW'(push) - QCW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[q_wr_ptr_reg] <= '{bits: word, index: s1_index_reg, last: s1_last_reg};
        end
    end

    assign m_block_bits  = q_mem_reg[q_rd_ptr_reg].bits;
    assign m_block_index = q_mem_reg[q_rd_ptr_reg].index;
    assign m_last_block  = q_mem_reg[q_rd_ptr_reg].last;

    // Checks on the queue, the pipeline and the frame restart.
    `BVBP_ASSERT_NOW(a_queue_bound, aclk, aresetn, 1'b1, q_count_reg <= QCW'(QDEPTH),
        "output queue count exceeds its depth")
    `BVBP_ASSERT_NOW(a_queue_no_overflow, aclk, aresetn, push && !pop,
        q_count_reg < QCW'(QDEPTH), "block pushed into a full output queue")
    `BVBP_ASSERT_NOW(a_last_is_emitted, aclk, aresetn, s1_valid_reg && s1_last_reg,
        s1_emit_reg, "final pixel of the volume did not close a block")
    `BVBP_ASSERT_NEXT(a_restart_clears, aclk, aresetn, restart,
        (x_reg == '0) && (y_reg == '0) && (z_reg == '0) && (bx_reg == '0),
        "dimension write did not restart the frame")

endmodule

`default_nettype wire
